@@ src/flia_pkg.sv @@
// shared types and codes for the free-list id allocator
package flia_pkg;

  // request kinds carried on the input side
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } req_cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  // tag of one link store entry
  typedef enum logic [1:0] {
    LINK_NEXT  = 2'd0,
    LINK_END   = 2'd1,
    LINK_ALLOC = 2'd2
  } link_tag_e;

  // controller state, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture a new request
    logic rd;    // read the link store entry
    logic ex;    // update state and load the result register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_stall;  // result register full and not being taken
  } dp_status_t;

endpackage

@@ src/free_list_id_allocator_core.sv @@
// top level of the free-list id allocator
//
//  channel   direction  tuser        tdata (low bit up)
//  s_axis    in         [0] cmd      [8:0] free_id, [15:9] zero
//  m_axis    out        -            [7:0] given_id, [9:8] status, [15:10] zero
//
// each request goes through a read step, which reads the link store entry (synchronous
// read port), and an execute step, which updates head and writes the entry back.
// the next request is taken in the cycle the current one writes back.
// reset makes the whole pool free at once; a fill count stands in for the initial links.
// a full result register that is not taken holds the write-back step and input ready.
module free_list_id_allocator_core #(
  parameter int POOL_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [8:0] free_id, [15:9] zero
  input  logic [0:0]  s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] given_id, [9:8] status, [15:10] zero
);
  import flia_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;
  logic [7:0] given_id;
  logic [1:0] status;

  flia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  flia_datapath #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .req_cmd_i      (s_axis_tuser[0]),
    .req_id_i       (s_axis_tdata[8:0]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_given_id_o (given_id),
    .out_status_o   (status)
  );

  assign m_axis_tdata = {6'b0, status, given_id};

endmodule

@@ src/flia_ctrl.sv @@
// controller state machine of the free-list id allocator
module flia_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  flia_pkg::dp_status_t  status_i,
  output flia_pkg::ctrl_cmd_t   cmd_o
);
  import flia_pkg::*;

  state_e state_q, state_d;
  logic   ex_done;
  logic   accept;

  assign ex_done     = (state_q == S_EXEC) && !status_i.out_stall;
  // a new request may enter in the cycle the previous one finishes
  assign req_ready_o = (state_q == S_IDLE) || ex_done;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!status_i.out_stall) state_d = accept ? S_READ : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.load = accept;
  assign cmd_o.rd   = (state_q == S_READ);
  assign cmd_o.ex   = ex_done;

  a_read_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_EXEC))
    else $error("read step not followed by execute step");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

endmodule

@@ src/flia_datapath.sv @@
// link store, free-list head, fill count and result register
module flia_datapath #(
  parameter int POOL_ENTRIES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  flia_pkg::ctrl_cmd_t   cmd_i,
  output flia_pkg::dp_status_t  status_o,
  input  logic                  req_cmd_i,
  input  logic [8:0]            req_id_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_given_id_o,
  output logic [1:0]            out_status_o
);
  import flia_pkg::*;

  localparam int IdW   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int FillW = IdW + 1;
  localparam logic [IdW-1:0] LastId    = IdW'(POOL_ENTRIES - 1);
  localparam logic [31:0]    PoolLimit = 32'(POOL_ENTRIES);

  typedef struct packed {
    link_tag_e      tag;
    logic [IdW-1:0] next;
  } link_t;

  // request registers
  req_cmd_e   cmd_q;
  logic [8:0] id_q;

  // free-list state
  logic [IdW-1:0]   head_q, head_d;
  logic             hv_q, hv_d;
  // entries from the fill count up are unwritten; their link is derived from the id
  logic [FillW-1:0] fill_q, fill_d;

  // link store
  link_t          mem_q [POOL_ENTRIES];
  link_t          rdata_q;
  logic [IdW-1:0] rd_addr_q;
  logic [IdW-1:0] rd_addr;
  logic           mem_we;
  link_t          mem_wd;

  // result register
  logic       out_valid_q;
  logic [7:0] out_given_q;
  status_e    out_status_q;
  logic [7:0] given;
  status_e    status;

  logic  untouched;
  logic  in_range;
  link_t link_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= req_cmd_e'(req_cmd_i);
      id_q  <= req_id_i;
    end
  end

  assign rd_addr  = (cmd_q == CMD_FREE) ? IdW'(id_q) : head_q;
  assign in_range = {23'b0, id_q} < PoolLimit;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[rd_addr_q] <= mem_wd;
    end
    if (cmd_i.rd) begin
      rdata_q   <= mem_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_comb begin
    untouched = {1'b0, rd_addr_q} >= fill_q;
    if (untouched) begin
      if (rd_addr_q == LastId) begin
        link_rd = '{tag: LINK_END, next: '0};
      end else begin
        link_rd = '{tag: LINK_NEXT, next: rd_addr_q + IdW'(1)};
      end
    end else begin
      link_rd = rdata_q;
    end

    head_d = head_q;
    hv_d   = hv_q;
    fill_d = fill_q;
    mem_we = 1'b0;
    mem_wd = '{tag: LINK_ALLOC, next: '0};
    given  = '0;
    status = ST_OK;

    if (cmd_i.ex) begin
      if (cmd_q == CMD_ALLOC) begin
        if (!hv_q) begin
          status = ST_EXHAUSTED;
        end else begin
          if (link_rd.tag == LINK_NEXT) begin
            head_d = link_rd.next;
          end else begin
            head_d = '0;
            hv_d   = 1'b0;
          end
          mem_we = 1'b1;
          given  = 8'(rd_addr_q);
          if (untouched) fill_d = fill_q + FillW'(1);
        end
      end else begin
        if (!in_range) begin
          status = ST_RANGE;
        end else if (link_rd.tag != LINK_ALLOC) begin
          status = ST_NOT_ALLOC;
        end else begin
          mem_we = 1'b1;
          mem_wd = hv_q ? '{tag: LINK_NEXT, next: head_q} : '{tag: LINK_END, next: '0};
          head_d = rd_addr_q;
          hv_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      hv_q        <= 1'b1;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      hv_q   <= hv_d;
      fill_q <= fill_d;
      if (cmd_i.ex) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ex) begin
      out_given_q  <= given;
      out_status_q <= status;
    end
  end

  assign status_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_given_id_o     = out_given_q;
  assign out_status_o       = out_status_q;

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(POOL_ENTRIES))
    else $error("fill count beyond pool size");

  a_fresh_pop_at_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ex && cmd_q == CMD_ALLOC && hv_q && untouched) |-> (fill_q == {1'b0, rd_addr_q}))
    else $error("allocation of an unwritten entry away from the fill count");

  a_free_sets_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ex && cmd_q == CMD_FREE && status == ST_OK) |=> (hv_q && head_q == $past(rd_addr_q)))
    else $error("freed entry did not become the list head");

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the free-list id allocator core
`timescale 1ns / 1ps

module tb_top;
  import flia_pkg::*;

  localparam int POOL = 256;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [7:0] given_id;
    status_e    status;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [8:0] free_id, [15:9] zero
  logic [0:0]  s_axis_tuser;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] given_id, [9:8] status, [15:10] zero

  // shadow of the pool: per-entry tag and next link, plus the list head
  link_tag_e  pool_tag [POOL];
  logic [7:0] pool_next [POOL];
  logic [7:0] head_id;
  logic       head_ok;
  logic [7:0] held_ids [$];   // ids the shadow pool counts as handed out

  reply_t reply_q [$];
  int     err_cnt;
  int     reply_cnt;
  int     status_seen [4];
  int     cycle_cnt;
  bit     idle_en;
  int     rx_hold_len;

  free_list_id_allocator_core #(
    .POOL_ENTRIES(POOL)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_cnt, reply_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic reply_t predict_reply(req_cmd_e cmd, logic [8:0] fid);
    reply_t     r;
    logic [7:0] id;
    r.given_id = '0;
    r.status   = ST_OK;
    if (cmd == CMD_ALLOC) begin
      if (!head_ok) begin
        r.status = ST_EXHAUSTED;
      end else begin
        id = head_id;
        if (pool_tag[id] == LINK_NEXT) begin
          head_id = pool_next[id];
        end else begin
          head_ok = 1'b0;
          head_id = '0;
        end
        pool_tag[id] = LINK_ALLOC;
        r.given_id   = id;
        held_ids.push_back(id);
      end
    end else if (fid >= POOL) begin
      r.status = ST_RANGE;
    end else begin
      id = fid[7:0];
      if (pool_tag[id] != LINK_ALLOC) begin
        r.status = ST_NOT_ALLOC;
      end else begin
        // freeing onto an empty list makes the entry the end of the list
        pool_tag[id]  = head_ok ? LINK_NEXT : LINK_END;
        pool_next[id] = head_id;
        head_id       = id;
        head_ok       = 1'b1;
        foreach (held_ids[k]) begin
          if (held_ids[k] == id) begin
            held_ids.delete(k);
            break;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_req(req_cmd_e cmd, logic [8:0] fid);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, fid};
    do @(posedge clk_i); while (!s_axis_tready);
    reply_q.push_back(predict_reply(cmd, fid));
  endtask

  // a currently held id, or any in-pool id when nothing is held
  function automatic logic [8:0] pick_held();
    if (held_ids.size() == 0) return 9'($urandom_range(0, POOL - 1));
    return {1'b0, held_ids[$urandom_range(0, held_ids.size() - 1)]};
  endfunction

  // weighted random request: alloc_pct allocate, held_pct free of a held id, rest any id
  task automatic send_random(int alloc_pct, int held_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) send_req(CMD_ALLOC, 9'($urandom_range(0, 511)));
    else if (roll < alloc_pct + held_pct) send_req(CMD_FREE, pick_held());
    else send_req(CMD_FREE, 9'($urandom_range(0, 511)));
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on reply %0d: %s got %0d expected %0d", reply_cnt, field, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reply_q.size() == 0) begin
        report_mismatch("unexpected transfer, data", int'(m_axis_tdata), 0);
      end else begin
        want = reply_q.pop_front();
        if (m_axis_tdata[7:0] !== want.given_id)
          report_mismatch("given_id", int'(m_axis_tdata[7:0]), int'(want.given_id));
        if (m_axis_tdata[9:8] !== want.status)
          report_mismatch("status", int'(m_axis_tdata[9:8]), int'(want.status));
        if (m_axis_tdata[15:10] !== 6'd0)
          report_mismatch("pad bits", int'(m_axis_tdata[15:10]), 0);
        status_seen[want.status]++;
      end
      reply_cnt++;
    end
  end

  // receiver side: random stalls, and a long hold when asked for
  initial begin
    int hold_cnt;
    m_axis_tready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_len > 0) begin
        m_axis_tready <= 1'b0;
        hold_cnt = rx_hold_len;
        rx_hold_len = 0;
        while (hold_cnt > 0) begin
          @(posedge clk_i);
          hold_cnt--;
        end
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_req(CMD_FREE, 9'd0);        // head of the list, not handed out
    send_req(CMD_FREE, 9'd255);      // end of the list, not handed out
    send_req(CMD_FREE, 9'd256);      // first id past the pool
    send_req(CMD_FREE, 9'd511);
    send_req(CMD_ALLOC, 9'h1FF);     // free_id is ignored on allocate
    send_req(CMD_ALLOC, 9'h000);
    send_req(CMD_ALLOC, 9'h155);
    send_req(CMD_FREE, 9'd1);
    send_req(CMD_FREE, 9'd1);        // double free
    send_req(CMD_FREE, 9'd200);      // still on the list
    send_req(CMD_ALLOC, 9'h0AA);     // gets 1 back
    send_req(CMD_FREE, 9'd2);
    send_req(CMD_FREE, 9'd0);
    send_req(CMD_ALLOC, 9'd0);
    send_req(CMD_ALLOC, 9'd0);
    send_req(CMD_ALLOC, 9'd0);
    send_req(CMD_FREE, 9'd1);
    send_req(CMD_FREE, 9'd3);
    send_req(CMD_FREE, 9'd384);
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    rx_hold_len = 250;
    repeat (40) send_random(50, 40);
    idle_en = 1'b1;
  endtask

  // mostly allocates: empties the pool and hits exhaustion repeatedly
  task automatic test_exhaust();
    repeat (500) send_random(85, 10);
  endtask

  // mostly frees of held ids, including frees onto an empty list
  task automatic test_refill();
    int k;
    for (k = 0; k < 450; k++) begin
      if (k < 40) send_random(92, 8);
      else send_random(10, 80);
    end
  endtask

  task automatic test_mixed();
    repeat (500) send_random(45, 40);
  endtask

  task automatic test_quiet_tail();
    idle_en = 1'b0;
    repeat (140) send_random(50, 40);
  endtask

  initial begin
    int settle;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    err_cnt       = 0;
    reply_cnt     = 0;
    cycle_cnt     = 0;
    rx_hold_len   = 0;
    idle_en       = 1'b1;
    foreach (status_seen[k]) status_seen[k] = 0;
    for (int k = 0; k < POOL; k++) begin
      pool_tag[k]  = LINK_NEXT;
      pool_next[k] = 8'(k + 1);
    end
    pool_tag[POOL - 1] = LINK_END;
    head_id = '0;
    head_ok = 1'b1;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_exhaust();
    test_refill();
    test_mixed();
    test_quiet_tail();
    s_axis_tvalid <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk_i);
    for (settle = 0; settle < SETTLE_CYCLES; settle++) @(posedge clk_i);
    if (reply_q.size() != 0) begin
      $display("%0d replies never arrived", reply_q.size());
      err_cnt++;
    end

    $display("checked %0d replies in %0d cycles", reply_cnt, cycle_cnt);
    $display("statuses: ok %0d, exhausted %0d, out of range %0d, not allocated %0d",
             status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_RANGE],
             status_seen[ST_NOT_ALLOC]);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/flia_pkg.sv
src/flia_ctrl.sv
src/flia_datapath.sv
src/free_list_id_allocator_core.sv
dv/tb_top.sv
